// ===== src/qmf_pkg.sv =====
// Shared types and constants for the circular queue with move-to-front.
// Used by the request/response interfaces, the controller and the top level.
package qmf_pkg;

   localparam int QMF_DEPTH      = 128;
   localparam int QMF_DATA_WIDTH = 32;
   localparam int VALUE_W        = 32;
   localparam int POS_W          = 8;
   localparam int CNT_W          = 8;
   localparam int CAP_W          = 8;
   localparam int CAP_RESET      = 128;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_CLEAR,
      OP_MOVE
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_EMPTY,
      STAT_BAD_POS
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_MV_FIRST,
      S_MV_SHIFT,
      S_MV_LAST
   } fsm_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [VALUE_W-1:0] data_value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] rear_value;
      logic [CNT_W-1:0]          count;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

endpackage

// ===== src/qmf_req_if.sv =====
// Request channel of the queue: valid/ready handshake with a req_type payload.
// Depends on qmf_pkg.
interface qmf_req_if;
   import qmf_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/qmf_rsp_if.sv =====
// Response channel of the queue: valid/ready handshake with a rsp_type payload.
// Depends on qmf_pkg.
interface qmf_rsp_if;
   import qmf_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/circular_queue_move_nth_front_top.sv =====
// Circular queue of words with push, pop, clear and move-nth-to-front.
// Depends on qmf_pkg, qmf_req_if, qmf_rsp_if, qmf_mem and qmf_ctrl.
// Usage:
//   req_ch carries one request (operation, data_value, position) under a
//   valid/ready handshake; rsp_ch returns exactly one response per request
//   (status, front/rear words, count, empty and full flags).
//   csr_write_en/csr_write_data set the capacity (0 acts as 1, values above
//   DEPTH act as DEPTH) and empty the queue; write only while idle.
// Sequence:
//   Push, clear, a move of position 1, a pop that empties the queue and every
//   rejected request finish on acceptance; the response is registered and
//   visible the cycle after acceptance. Any other pop adds one read of the new
//   front (state S_POP_RD). A move of position n > 1 runs one read of the
//   picked entry, n - 1 read/write shifts and one write of the front.
// Reset:
//   Empties the queue and sets the capacity to 128 (or DEPTH if smaller).
//   Storage is not cleared; entries are only read after being written.
// Stall:
//   A waiting response does not block acceptance when the receiver takes it
//   in the same cycle; otherwise req_ch.ready stays low until it is taken.
module circular_queue_move_nth_front_top #(
   parameter int DEPTH      = qmf_pkg::QMF_DEPTH,
   parameter int DATA_WIDTH = qmf_pkg::QMF_DATA_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [qmf_pkg::CAP_W-1:0] csr_write_data,
   qmf_req_if.sink                   req_ch,
   qmf_rsp_if.source                 rsp_ch
);
   import qmf_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   qmf_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   qmf_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== src/qmf_mem.sv =====
// Queue storage: one write port, one read port, registered read data.
// Depends on qmf_pkg for default sizes.
module qmf_mem #(
   parameter int DEPTH      = qmf_pkg::QMF_DEPTH,
   parameter int DATA_WIDTH = qmf_pkg::QMF_DATA_WIDTH,
   localparam int ADDR_W    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] storage_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= storage_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/qmf_ctrl.sv =====
// Queue controller: pointers, count, cached front/rear words, the move
// sequencer over the storage memory and the response register.
// Depends on qmf_pkg, qmf_req_if and qmf_rsp_if.
module qmf_ctrl #(
   parameter int DEPTH      = qmf_pkg::QMF_DEPTH,
   parameter int DATA_WIDTH = qmf_pkg::QMF_DATA_WIDTH,
   localparam int ADDR_W    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [qmf_pkg::CAP_W-1:0]   csr_write_data,
   qmf_req_if.sink                     req_ch,
   qmf_rsp_if.source                   rsp_ch,
   output logic                        mem_wr_en,
   output logic [ADDR_W-1:0]           mem_wr_addr,
   output logic [DATA_WIDTH-1:0]       mem_wr_data,
   output logic [ADDR_W-1:0]           mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]       mem_rd_data
);
   import qmf_pkg::*;

   localparam int AW    = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
   localparam int EXT_W = DATA_WIDTH + VALUE_W;

   function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
      if (v == '0) return CAP_W'(1);
      if (int'(v) > DEPTH) return CAP_W'(DEPTH);
      return v;
   endfunction

   fsm_type               state_ff, state_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [ADDR_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] moved_ff, moved_in;
   logic [ADDR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      shift_cnt_ff, shift_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  finish;
   status_type            status;
   logic [AW-1:0]         cap_w;
   logic [ADDR_W-1:0]     cap_last;
   logic [ADDR_W-1:0]     head_inc, tail_inc, wr_dec, rd_dec, move_slot;
   logic [AW-1:0]         slot_sum;
   logic [CAP_W-1:0]      csr_cap;
   logic [EXT_W-1:0]      push_ext, front_ext, rear_ext;
   logic [DATA_WIDTH-1:0] push_word;

   assign req_ch.ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // Pointer arithmetic modulo the effective capacity
   assign cap_w     = AW'(cap_ff);
   assign cap_last  = ADDR_W'(cap_ff - CAP_W'(1));
   assign head_inc  = (AW'(head_ff) + AW'(1) == cap_w) ? '0 : head_ff + ADDR_W'(1);
   assign tail_inc  = (AW'(tail_ff) + AW'(1) == cap_w) ? '0 : tail_ff + ADDR_W'(1);
   assign wr_dec    = (wr_ptr_ff == '0) ? cap_last : wr_ptr_ff - ADDR_W'(1);
   assign rd_dec    = (rd_ptr_ff == '0) ? cap_last : rd_ptr_ff - ADDR_W'(1);
   assign slot_sum  = AW'(head_ff) + AW'(req_ch.payload.position) - AW'(1);
   assign move_slot = ADDR_W'((slot_sum >= cap_w) ? slot_sum - cap_w : slot_sum);
   assign csr_cap   = eff_cap(csr_write_data);

   assign push_ext  = EXT_W'($unsigned(req_ch.payload.data_value));
   assign push_word = push_ext[DATA_WIDTH-1:0];
   assign front_ext = EXT_W'(front_in);
   assign rear_ext  = EXT_W'(rear_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= eff_cap(CAP_W'(CAP_RESET));
         head_ff      <= '0;
         tail_ff      <= ADDR_W'(eff_cap(CAP_W'(CAP_RESET)) - CAP_W'(1));
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      rear_ff      <= rear_in;
      moved_ff     <= moved_in;
      wr_ptr_ff    <= wr_ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      shift_cnt_ff <= shift_cnt_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      moved_in     = moved_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      shift_cnt_in = shift_cnt_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_ptr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = rd_ptr_ff;
      finish       = 1'b0;
      status       = STAT_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_ch.payload.operation)
                  OP_PUSH: begin
                     finish = 1'b1;
                     if (count_ff >= cap_ff) begin
                        status = STAT_FULL;
                     end else begin
                        tail_in     = tail_inc;
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tail_inc;
                        mem_wr_data = push_word;
                        rear_in     = push_word;
                        if (count_ff == '0) begin
                           front_in = push_word;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        finish = 1'b1;
                        status = STAT_EMPTY;
                     end else begin
                        head_in     = head_inc;
                        count_in    = count_ff - CNT_W'(1);
                        mem_rd_addr = head_inc;
                        // fetch the new front unless the queue drains
                        if (count_ff == CNT_W'(1)) begin
                           finish = 1'b1;
                        end else begin
                           state_in = S_POP_RD;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     finish   = 1'b1;
                     count_in = '0;
                     head_in  = '0;
                     tail_in  = cap_last;
                  end
                  OP_MOVE: begin
                     if (count_ff == '0) begin
                        finish = 1'b1;
                        status = STAT_EMPTY;
                     end else if (req_ch.payload.position == '0 ||
                                  req_ch.payload.position > count_ff) begin
                        finish = 1'b1;
                        status = STAT_BAD_POS;
                     end else if (req_ch.payload.position == POS_W'(1)) begin
                        finish = 1'b1;
                     end else begin
                        mem_rd_addr  = move_slot;
                        wr_ptr_in    = move_slot;
                        shift_cnt_in = CNT_W'(req_ch.payload.position - POS_W'(1));
                        state_in     = S_MV_FIRST;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            front_in = mem_rd_data;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         S_MV_FIRST: begin
            // hold the picked word, start reading the entry just below it
            moved_in    = mem_rd_data;
            mem_rd_addr = wr_dec;
            rd_ptr_in   = wr_dec;
            state_in    = S_MV_SHIFT;
         end
         S_MV_SHIFT: begin
            // shift one entry toward the rear, read the next one down
            mem_wr_en   = 1'b1;
            mem_wr_addr = wr_ptr_ff;
            mem_wr_data = mem_rd_data;
            if (wr_ptr_ff == tail_ff) begin
               rear_in = mem_rd_data;
            end
            wr_ptr_in   = rd_ptr_ff;
            rd_ptr_in   = rd_dec;
            mem_rd_addr = rd_dec;
            if (shift_cnt_ff == CNT_W'(1)) begin
               state_in = S_MV_LAST;
            end else begin
               shift_cnt_in = shift_cnt_ff - CNT_W'(1);
            end
         end
         S_MV_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = head_ff;
            mem_wr_data = moved_ff;
            front_in    = moved_ff;
            finish      = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the queue
      if (csr_write_en) begin
         cap_in   = csr_cap;
         head_in  = '0;
         tail_in  = ADDR_W'(csr_cap - CAP_W'(1));
         count_in = '0;
      end

      rsp_in = rsp_ff;
      if (finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status;
         rsp_in.front_value = (count_in == '0) ? '0 : front_ext[VALUE_W-1:0];
         rsp_in.rear_value  = (count_in == '0) ? '0 : rear_ext[VALUE_W-1:0];
         rsp_in.count       = count_in;
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.is_full     = (count_in == cap_ff);
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("element count above capacity");

   a_ptr_in_cap: assert property (@(posedge clock) disable iff (reset)
      (AW'(head_ff) < cap_w) && (AW'(tail_ff) < cap_w))
      else $error("head or tail pointer outside capacity");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !rsp_valid_ff)
      else $error("response pending while a request is in progress");

   a_shift_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MV_SHIFT |-> shift_cnt_ff != '0)
      else $error("shift count exhausted inside move");

   a_move_depth: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MV_FIRST |-> count_ff > CNT_W'(1) && !mem_wr_en)
      else $error("move started on a queue of fewer than two elements");

endmodule
